// ----- hdl/ppbb_pkg.sv -----
// ----------------------------------------------------------------------------
// ppbb_pkg
// Shared types and constants of the ping-pong byte buffer.
// ----------------------------------------------------------------------------
package ppbb_pkg;

  localparam int BANK_BYTES = 64;
  localparam int POS_W      = 7;
  localparam int MEM_DEPTH  = 2 * BANK_BYTES;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam logic [POS_W-1:0] BANK_LIMIT = POS_W'(BANK_BYTES);

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SWITCH  = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_UPDATE  = 3'd4,
    CMD_ESWITCH = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       data_byte;
    logic             bank;
    logic [POS_W-1:0] start_offset;
    logic [POS_W-1:0] length;
  } in_t;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic             old_bank;
    logic [POS_W-1:0] old_size;
    logic             error;
    logic             bank0_empty;
    logic             bank1_empty;
    logic             free_bank;
    logic             none_free;
    logic             active_bank;
    logic             active_full;
    logic             active_empty;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;
    logic do_push;
    logic do_pop;
    logic do_switch;
    logic do_clear;
    logic do_update;
    logic err;
  } ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic upd_ok;
    logic act_empty;
  } stat_t;

endpackage

// ----- hdl/ppbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppbb_ctrl
// Command decoder and handshake state machine of the ping-pong byte buffer.
// ----------------------------------------------------------------------------
module ppbb_ctrl import ppbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] command_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   exec;

  assign exec = start && (state_q == ST_IDLE);

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.exec = exec;
    if (exec) begin
      case (cmd_e'(command_i))
        CMD_PUSH: begin
          ctrl_o.do_push = stat_i.push_ok;
          ctrl_o.err     = !stat_i.push_ok;
        end
        CMD_POP: begin
          ctrl_o.do_pop = stat_i.pop_ok;
          ctrl_o.err    = !stat_i.pop_ok;
        end
        CMD_SWITCH:  ctrl_o.do_switch = 1'b1;
        CMD_CLEAR:   ctrl_o.do_clear  = 1'b1;
        CMD_UPDATE: begin
          ctrl_o.do_update = stat_i.upd_ok;
          ctrl_o.err       = !stat_i.upd_ok;
        end
        CMD_ESWITCH: ctrl_o.do_switch = stat_i.act_empty;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (exec) begin
            state_q <= ST_RESP;
            done_q  <= 1'b1;
          end
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = (state_q == ST_RESP);
  assign done_o = done_q;

endmodule

// ----- hdl/ppbb_dpath.sv -----
// ----------------------------------------------------------------------------
// ppbb_dpath
// Bank store, bank positions and counts, active bank bit and result registers.
// ----------------------------------------------------------------------------
module ppbb_dpath import ppbb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   cmd_i,
  input  ctrl_t ctrl_i,
  output stat_t stat_o,
  output out_t  res_o
);

  logic [7:0]       mem [MEM_DEPTH];
  logic             act_q;
  logic [POS_W-1:0] cnt_q [2];
  logic [POS_W-1:0] pos_q [2];

  logic [7:0]       rdata_q;
  logic             rd_valid_q;
  logic             err_q;
  logic             old_bank_q;
  logic [POS_W-1:0] old_size_q;

  logic [POS_W-1:0] act_pos;
  logic [POS_W-1:0] act_cnt;
  logic [POS_W:0]   upd_end;
  logic [MEM_AW-1:0] addr;

  assign act_pos = pos_q[act_q];
  assign act_cnt = cnt_q[act_q];
  assign upd_end = {1'b0, cmd_i.start_offset} + {1'b0, cmd_i.length};
  assign addr    = (act_q ? MEM_AW'(BANK_BYTES) : '0) + MEM_AW'(act_pos);

  assign stat_o.push_ok   = (act_pos < BANK_LIMIT) && (act_cnt < BANK_LIMIT);
  assign stat_o.pop_ok    = (act_cnt != '0) && (act_pos < BANK_LIMIT);
  assign stat_o.upd_ok    = (upd_end <= {1'b0, BANK_LIMIT});
  assign stat_o.act_empty = (act_cnt == '0);

  // bank store, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_push) begin
      mem[addr] <= cmd_i.data_byte;
    end
    if (ctrl_i.do_pop) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      cnt_q[0]   <= '0;
      cnt_q[1]   <= '0;
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      rd_valid_q <= 1'b0;
      err_q      <= 1'b0;
      old_bank_q <= 1'b0;
      old_size_q <= '0;
    end else if (ctrl_i.exec) begin
      rd_valid_q <= ctrl_i.do_pop;
      err_q      <= ctrl_i.err;
      old_bank_q <= 1'b0;
      old_size_q <= '0;
      if (ctrl_i.do_push) begin
        pos_q[act_q] <= act_pos + POS_W'(1);
        cnt_q[act_q] <= act_cnt + POS_W'(1);
      end
      if (ctrl_i.do_pop) begin
        pos_q[act_q] <= act_pos + POS_W'(1);
        cnt_q[act_q] <= act_cnt - POS_W'(1);
      end
      if (ctrl_i.do_switch) begin
        old_bank_q   <= act_q;
        old_size_q   <= act_pos;
        pos_q[act_q] <= '0;
        cnt_q[act_q] <= '0;
        act_q        <= !act_q;
      end
      if (ctrl_i.do_clear) begin
        pos_q[cmd_i.bank] <= '0;
        cnt_q[cmd_i.bank] <= '0;
      end
      if (ctrl_i.do_update) begin
        pos_q[cmd_i.bank] <= cmd_i.start_offset;
        cnt_q[cmd_i.bank] <= cmd_i.length;
      end
    end
  end

  // status is taken from the registers after the command
  always_comb begin
    res_o              = '0;
    res_o.read_byte    = rd_valid_q ? rdata_q : 8'h00;
    res_o.old_bank     = old_bank_q;
    res_o.old_size     = old_size_q;
    res_o.error        = err_q;
    res_o.bank0_empty  = (cnt_q[0] == '0);
    res_o.bank1_empty  = (cnt_q[1] == '0);
    res_o.free_bank    = (cnt_q[0] != '0) && (cnt_q[1] == '0);
    res_o.none_free    = (cnt_q[0] != '0) && (cnt_q[1] != '0);
    res_o.active_bank  = act_q;
    res_o.active_full  = (act_pos == BANK_LIMIT);
    res_o.active_empty = (act_cnt == '0);
  end

endmodule

// ----- hdl/ping_pong_byte_buffer.sv -----
// ----------------------------------------------------------------------------
// ping_pong_byte_buffer
// Two byte banks used in ping-pong fashion with push, pop and bank control.
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive cmd_i and raise start; the command transfers at a
//   rising edge where start is high and busy is low.
//   result channel: one result per command on res_o, marked by done_o for
//   exactly one cycle, the cycle after the command transfer.
//   busy is high during the result cycle, so no new command is taken until
//   the result of the last one has been given.
//   the receiver cannot stall: a result not taken in its done_o cycle is lost.
//   reset clears the active bank bit and both bank positions and counts; the
//   bank store itself is not cleared, and bytes never pushed read as garbage.
//   refused pushes, pops and updates set error and change nothing.
// ----------------------------------------------------------------------------
module ping_pong_byte_buffer import ppbb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  cmd_i,
  output logic busy,
  output logic done_o,
  output out_t res_o
);

  ctrl_t ctrl;
  stat_t stat;

  ppbb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy),
    .done_o    (done_o)
  );

  ppbb_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

// ----- hdl/ppbb_checker.sv -----
// ----------------------------------------------------------------------------
// ppbb_checker
// Port-level checks of the ping-pong byte buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ppbb_checker import ppbb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input out_t res_o
);

  // each transfer gives its result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after command transfer");

  // no result without a command transfer before it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without command");

  // a refused access never returns data
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error) |-> (res_o.read_byte == 8'h00))
    else $error("data returned with error");

  // status flags agree with each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.none_free == (!res_o.bank0_empty && !res_o.bank1_empty))
                && (res_o.free_bank == (!res_o.bank0_empty && res_o.bank1_empty))))
    else $error("inconsistent bank flags");

  // a switch with a nonzero old size hands the bank off and flips the active bank
  a_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.old_size != '0) |-> (res_o.active_bank != res_o.old_bank))
    else $error("switch did not flip active bank");

endmodule

bind ping_pong_byte_buffer ppbb_checker u_ppbb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// ----- tb/ping_pong_byte_buffer_tb.sv -----
// ----------------------------------------------------------------------------
// ping_pong_byte_buffer_tb
// Self-checking bench for the ping-pong byte buffer. A directed table covers
// reset status, refused pushes, pops and updates, empty-switch and the unused
// codes. Random bursts of fill, update and drain sequences then run under
// several sender idle rates. Results are checked against an in-bench model
// of the two banks, or against the expected value of a typed table row.
// ----------------------------------------------------------------------------
module ping_pong_byte_buffer_tb;
  import ppbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 490;

  // pop or update refused on empty banks, status right after reset
  localparam out_t EXP_EMPTY_ERR = '{read_byte: 8'h00, old_bank: 1'b0, old_size: '0,
                                     error: 1'b1, bank0_empty: 1'b1, bank1_empty: 1'b1,
                                     free_bank: 1'b0, none_free: 1'b0, active_bank: 1'b0,
                                     active_full: 1'b0, active_empty: 1'b1};
  localparam out_t EXP_IDLE_ACT1 = '{read_byte: 8'h00, old_bank: 1'b0, old_size: '0,
                                     error: 1'b0, bank0_empty: 1'b1, bank1_empty: 1'b1,
                                     free_bank: 1'b0, none_free: 1'b0, active_bank: 1'b1,
                                     active_full: 1'b0, active_empty: 1'b1};

  typedef struct {
    in_t  cmd;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  in_t  cmd_i;
  logic busy;
  logic done_o;
  out_t res_o;

  // shadow of the buffer state
  logic             act_sel;
  logic [POS_W-1:0] fill_cnt [2];
  logic [POS_W-1:0] rw_pos   [2];
  logic [7:0]       byte_mem [MEM_DEPTH];
  bit               byte_written [MEM_DEPTH];

  out_t pending_results[$];
  int   errs;
  int   sent;
  int   idle_pct;
  int   stall_cycles;

  ping_pong_byte_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t mk(logic [2:0] c, logic [7:0] d, logic b, logic [POS_W-1:0] s,
                             logic [POS_W-1:0] l);
    mk = '{command: c, data_byte: d, bank: b, start_offset: s, length: l};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    rand_pos = POS_W'($urandom_range(127));
  endfunction

  task automatic swap_banks(output logic ob, output logic [POS_W-1:0] os);
    ob = act_sel;
    os = rw_pos[act_sel];
    fill_cnt[act_sel] = '0;
    rw_pos[act_sel] = '0;
    act_sel = ~act_sel;
  endtask

  // next state and result of one command
  task automatic buffer_step(input in_t c, output out_t r);
    logic a;
    int   idx;
    a = act_sel;
    r = '0;
    case (c.command)
      CMD_PUSH: begin
        if (rw_pos[a] >= BANK_LIMIT || fill_cnt[a] >= BANK_LIMIT) begin
          r.error = 1'b1;
        end else begin
          idx = int'(a) * BANK_BYTES + int'(rw_pos[a]);
          byte_mem[idx] = c.data_byte;
          byte_written[idx] = 1'b1;
          rw_pos[a]++;
          fill_cnt[a]++;
        end
      end
      CMD_POP: begin
        if (fill_cnt[a] == 0 || rw_pos[a] >= BANK_LIMIT) begin
          r.error = 1'b1;
        end else begin
          idx = int'(a) * BANK_BYTES + int'(rw_pos[a]);
          r.read_byte = byte_mem[idx];
          rw_pos[a]++;
          fill_cnt[a]--;
        end
      end
      CMD_SWITCH: swap_banks(r.old_bank, r.old_size);
      CMD_CLEAR: begin
        fill_cnt[c.bank] = '0;
        rw_pos[c.bank] = '0;
      end
      CMD_UPDATE: begin
        if (int'(c.start_offset) + int'(c.length) > BANK_BYTES) begin
          r.error = 1'b1;
        end else begin
          rw_pos[c.bank] = c.start_offset;
          fill_cnt[c.bank] = c.length;
        end
      end
      CMD_ESWITCH: begin
        if (fill_cnt[a] == 0) swap_banks(r.old_bank, r.old_size);
      end
      default: ;
    endcase
    r.bank0_empty  = (fill_cnt[0] == 0);
    r.bank1_empty  = (fill_cnt[1] == 0);
    r.free_bank    = !r.bank0_empty && r.bank1_empty;
    r.none_free    = !r.bank0_empty && !r.bank1_empty;
    r.active_bank  = act_sel;
    r.active_full  = (rw_pos[act_sel] == BANK_LIMIT);
    r.active_empty = (fill_cnt[act_sel] == 0);
  endtask

  // a pop that would read a byte never pushed is turned into a push
  function automatic bit pop_hits_unwritten();
    pop_hits_unwritten = fill_cnt[act_sel] != 0 && rw_pos[act_sel] < BANK_LIMIT &&
                         !byte_written[int'(act_sel) * BANK_BYTES + int'(rw_pos[act_sel])];
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send(input in_t item, input bit typed = 1'b0, input out_t want = '0);
    out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    if (item.command == CMD_POP && pop_hits_unwritten()) item.command = CMD_PUSH;
    start <= 1'b1;
    cmd_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    buffer_step(item, predicted);
    pending_results.push_back(typed ? want : predicted);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_burst();
    int k;
    int s;
    int l;
    if ($urandom_range(99) < 55) begin
      // fill the active bank, point it at the written bytes, drain it
      send(mk(CMD_CLEAR, 8'($urandom), act_sel, rand_pos(), rand_pos()));
      k = ($urandom_range(7) == 0) ? BANK_BYTES : $urandom_range(1, 12);
      if (k == BANK_BYTES && $urandom_range(1)) k++;
      repeat (k) send(mk(CMD_PUSH, 8'($urandom), 1'($urandom), rand_pos(), rand_pos()));
      k = (k > BANK_BYTES) ? BANK_BYTES : k;
      s = $urandom_range(0, k - 1);
      l = $urandom_range(1, k - s);
      send(mk(CMD_UPDATE, 8'($urandom), act_sel, POS_W'(s), POS_W'(l)));
      repeat (l + $urandom_range(1)) begin
        send(mk(CMD_POP, 8'($urandom), 1'($urandom), rand_pos(), rand_pos()));
      end
      case ($urandom_range(2))
        0: send(mk(CMD_SWITCH, 8'($urandom), 1'($urandom), rand_pos(), rand_pos()));
        1: send(mk(CMD_ESWITCH, 8'($urandom), 1'($urandom), rand_pos(), rand_pos()));
        default: ;
      endcase
    end else begin
      if ($urandom_range(1)) begin
        s = $urandom_range(0, BANK_BYTES);
        l = $urandom_range(0, BANK_BYTES - s);
      end else begin
        s = $urandom_range(127);
        l = $urandom_range(127);
      end
      send(mk(3'($urandom_range(7)), 8'($urandom), 1'($urandom), POS_W'(s), POS_W'(l)));
    end
  endtask

  task automatic chk_field(input string name, input logic [7:0] want_v,
                           input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_t w;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        errs++;
      end else begin
        w = pending_results.pop_front();
        chk_field("read_byte",    w.read_byte,    res_o.read_byte);
        chk_field("old_bank",     w.old_bank,     res_o.old_bank);
        chk_field("old_size",     w.old_size,     res_o.old_size);
        chk_field("error",        w.error,        res_o.error);
        chk_field("bank0_empty",  w.bank0_empty,  res_o.bank0_empty);
        chk_field("bank1_empty",  w.bank1_empty,  res_o.bank1_empty);
        chk_field("free_bank",    w.free_bank,    res_o.free_bank);
        chk_field("none_free",    w.none_free,    res_o.none_free);
        chk_field("active_bank",  w.active_bank,  res_o.active_bank);
        chk_field("active_full",  w.active_full,  res_o.active_full);
        chk_field("active_empty", w.active_empty, res_o.active_empty);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    dir_row_t dir_table[23];
    int       phase_pct[4];
    int       target;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    errs = 0;
    sent = 0;
    idle_pct = 0;
    stall_cycles = 0;
    act_sel = 1'b0;
    fill_cnt = '{default: '0};
    rw_pos = '{default: '0};
    byte_mem = '{default: '0};
    byte_written = '{default: 1'b0};
    phase_pct = '{0, 77, 0, 29};

    dir_table = '{
      '{mk(CMD_POP,     8'h00, 1'b0, 7'd0,   7'd0),   1'b1, EXP_EMPTY_ERR},
      '{mk(CMD_PUSH,    8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_PUSH,    8'hFF, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_UPDATE,  8'h00, 1'b0, 7'd0,   7'd2),   1'b0, '0},
      '{mk(CMD_POP,     8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_POP,     8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_POP,     8'h00, 1'b0, 7'd0,   7'd0),   1'b1, EXP_EMPTY_ERR},
      '{mk(CMD_UPDATE,  8'h00, 1'b1, 7'd127, 7'd127), 1'b1, EXP_EMPTY_ERR},
      '{mk(CMD_UPDATE,  8'h00, 1'b0, 7'd64,  7'd0),   1'b0, '0},
      '{mk(CMD_PUSH,    8'hA5, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_POP,     8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_UPDATE,  8'h00, 1'b1, 7'd0,   7'd64),  1'b0, '0},
      '{mk(CMD_ESWITCH, 8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_ESWITCH, 8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_PUSH,    8'h5A, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_CLEAR,   8'h00, 1'b1, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_RSVD6,   8'h00, 1'b0, 7'd0,   7'd0),   1'b1, EXP_IDLE_ACT1},
      '{mk(CMD_RSVD7,   8'hFF, 1'b1, 7'd127, 7'd127), 1'b0, '0},
      '{mk(CMD_SWITCH,  8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_UPDATE,  8'h00, 1'b0, 7'd0,   7'd64),  1'b0, '0},
      '{mk(CMD_UPDATE,  8'h00, 1'b1, 7'd1,   7'd63),  1'b0, '0},
      '{mk(CMD_CLEAR,   8'h00, 1'b1, 7'd0,   7'd0),   1'b0, '0},
      '{mk(CMD_CLEAR,   8'h00, 1'b0, 7'd0,   7'd0),   1'b0, '0}
    };

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i]) send(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want);
    drain();

    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      target = sent + PHASE_ITEMS;
      while (sent < target) random_burst();
      // hold the sender until every result of this phase is back
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (errs == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
